// ===== rtl/core/slx_pkg.sv =====
// shared types, character constants and classification helpers of the source lexer
package slx_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COL_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int POS_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int TDATA_W         = 48;
    localparam int TUSER_W         = 5;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // tdata bit positions, lowest field first
    localparam int TD_VALUE_LO = 0;
    localparam int TD_LINE_LO  = TD_VALUE_LO + BYTE_W;
    localparam int TD_COL_LO   = TD_LINE_LO + POS_W;
    localparam int TD_ERR_LO   = TD_COL_LO + POS_W;
    localparam int TD_USED_W   = TD_ERR_LO + 3;

    localparam logic [7:0] CH_OPEN    = 8'h7B;
    localparam logic [7:0] CH_CLOSE   = 8'h7D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_ESCID,
        MODE_STRING,
        MODE_STRESC,
        MODE_NUMBER,
        MODE_HALT
    } mode_t;

    typedef enum logic [1:0] {
        EV_CHAR,
        EV_END,
        EV_BRACE,
        EV_ERROR
    } event_t;

    typedef enum logic [2:0] {
        KIND_NUMBER,
        KIND_IDENT,
        KIND_STRING,
        KIND_ESCID,
        KIND_OPEN,
        KIND_CLOSE
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_UNEXPECTED,
        ERR_POINT,
        ERR_ESCAPE,
        ERR_UNTERMINATED
    } err_t;

    typedef struct packed {
        event_t            ev;
        kind_t             kind;
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  col;
        err_t              err;
        logic              last;
    } res_t;

    // results caused by one source byte
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } grp_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_idch(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == CH_POINT) || (c == CH_QUEST) || (c == CH_MINUS) ||
               (c == CH_UNDER) || (c == CH_PLUS) || (c == CH_SLASH) || (c == CH_STAR);
    endfunction

    // bit 8 set when the escape is known
    function automatic logic [8:0] decode_escape(input logic [7:0] c);
        logic [8:0] d;
        case (c)
            8'h6E:     d = {1'b1, 8'h0A};
            8'h72:     d = {1'b1, 8'h0D};
            CH_QUOTE:  d = {1'b1, CH_QUOTE};
            8'h61:     d = {1'b1, 8'h07};
            8'h65:     d = {1'b1, 8'h1B};
            8'h66:     d = {1'b1, 8'h0C};
            8'h74:     d = {1'b1, 8'h09};
            8'h76:     d = {1'b1, 8'h0B};
            CH_BSLASH: d = {1'b1, CH_BSLASH};
            default:   d = '0;
        endcase
        return d;
    endfunction

    function automatic kind_t mode_kind(input mode_t m);
        kind_t k;
        case (m)
            MODE_IDENT:  k = KIND_IDENT;
            MODE_ESCID:  k = KIND_ESCID;
            MODE_NUMBER: k = KIND_NUMBER;
            default:     k = KIND_STRING;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/slx_front.sv =====
// front end: position tracking, character classification and result grouping per byte
module slx_front
    import slx_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF,
    parameter int COL_BITS  = COL_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_eoi,
    output logic              push,
    output grp_t              push_grp
);

    localparam int LW = (LINE_BITS > POS_W) ? LINE_BITS : POS_W;
    localparam int CW = (COL_BITS > POS_W) ? COL_BITS : POS_W;

    mode_t                mode_reg, mode_next;
    logic                 seen_reg, seen_next;
    logic [LINE_BITS-1:0] line_reg, line_next, line_step;
    logic [COL_BITS-1:0]  col_reg, col_next, col_step;
    logic [LINE_BITS-1:0] sline_reg, sline_next;
    logic [COL_BITS-1:0]  scol_reg, scol_next;

    res_t       a_r, b_r, c_r, idle_r;
    logic       a_v, b_v, c_v, idle_v, idle_num, take_idle;
    mode_t      idle_mode;
    logic [8:0] esc;
    logic [1:0] n_res;
    res_t       o0, o1;

    function automatic logic [POS_W-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [LW-1:0] e;
        e = LW'(v);
        return (e > LW'(POS_MAX)) ? POS_MAX : e[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_col(input logic [COL_BITS-1:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        return (e > CW'(POS_MAX)) ? POS_MAX : e[POS_W-1:0];
    endfunction

    // position after this byte
    always_comb begin
        if (in_byte == CH_NEWLINE) begin
            line_step = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
            col_step  = '0;
        end else begin
            line_step = line_reg;
            col_step  = (col_reg == '1) ? col_reg : col_reg + COL_BITS'(1);
        end
    end

    // what the byte does when seen in idle mode
    always_comb begin
        idle_v    = 1'b0;
        idle_num  = 1'b0;
        idle_mode = MODE_IDLE;
        idle_r    = '0;
        idle_r.line = sat_line(line_step);
        idle_r.col  = sat_col(col_step);
        if (in_byte == CH_OPEN) begin
            idle_v      = 1'b1;
            idle_r.ev   = EV_BRACE;
            idle_r.kind = KIND_OPEN;
        end else if (in_byte == CH_CLOSE) begin
            idle_v      = 1'b1;
            idle_r.ev   = EV_BRACE;
            idle_r.kind = KIND_CLOSE;
        end else if (is_idch(in_byte)) begin
            idle_v       = 1'b1;
            idle_mode    = MODE_IDENT;
            idle_r.kind  = KIND_IDENT;
            idle_r.value = in_byte;
        end else if (in_byte == CH_QUOTE) begin
            idle_mode = MODE_STRING;
        end else if (in_byte == CH_APOS) begin
            idle_mode = MODE_ESCID;
        end else if (is_space(in_byte)) begin
            idle_mode = MODE_IDLE;
        end else if (is_digit(in_byte)) begin
            idle_v       = 1'b1;
            idle_num     = 1'b1;
            idle_mode    = MODE_NUMBER;
            idle_r.kind  = KIND_NUMBER;
            idle_r.value = in_byte;
        end else begin
            idle_v      = 1'b1;
            idle_mode   = MODE_HALT;
            idle_r.ev   = EV_ERROR;
            idle_r.kind = KIND_NUMBER;
            idle_r.err  = ERR_UNEXPECTED;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        seen_next  = seen_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        take_idle  = 1'b0;
        esc        = decode_escape(in_byte);
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        a_r        = '0;
        a_r.kind   = mode_kind(mode_reg);
        a_r.line   = sat_line(sline_reg);
        a_r.col    = sat_col(scol_reg);
        b_r        = idle_r;
        c_r        = '0;

        if (in_accept) begin
            if (mode_reg == MODE_HALT) begin
                if (in_eoi) begin
                    mode_next  = MODE_IDLE;
                    seen_next  = 1'b0;
                    line_next  = LINE_BITS'(1);
                    col_next   = '0;
                    sline_next = LINE_BITS'(1);
                    scol_next  = '0;
                end
            end else begin
                line_next = line_step;
                col_next  = col_step;
                case (mode_reg)
                    MODE_IDLE: begin
                        take_idle = 1'b1;
                    end
                    MODE_IDENT, MODE_ESCID: begin
                        a_v = 1'b1;
                        if (is_idch(in_byte)) begin
                            a_r.value = in_byte;
                        end else begin
                            a_r.ev    = EV_END;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        a_v = 1'b1;
                        if (in_byte == CH_POINT) begin
                            if (seen_reg) begin
                                a_r.ev    = EV_ERROR;
                                a_r.err   = ERR_POINT;
                                a_r.line  = sat_line(line_step);
                                a_r.col   = sat_col(col_step);
                                mode_next = MODE_HALT;
                            end else begin
                                seen_next = 1'b1;
                                a_r.value = in_byte;
                            end
                        end else if (is_digit(in_byte)) begin
                            a_r.value = in_byte;
                        end else begin
                            a_r.ev    = EV_END;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (in_byte == CH_BSLASH) begin
                            mode_next = MODE_STRESC;
                        end else if (in_byte == CH_QUOTE) begin
                            a_v       = 1'b1;
                            a_r.ev    = EV_END;
                            mode_next = MODE_IDLE;
                        end else begin
                            a_v       = 1'b1;
                            a_r.value = in_byte;
                        end
                    end
                    MODE_STRESC: begin
                        a_v = 1'b1;
                        if (esc[8]) begin
                            a_r.value = esc[7:0];
                            mode_next = MODE_STRING;
                        end else begin
                            a_r.ev    = EV_ERROR;
                            a_r.err   = ERR_ESCAPE;
                            a_r.line  = sat_line(line_step);
                            a_r.col   = sat_col(col_step);
                            mode_next = MODE_HALT;
                        end
                    end
                    default: begin
                        mode_next = mode_reg;
                    end
                endcase

                // terminating byte goes through idle handling again
                if (take_idle) begin
                    b_v        = idle_v;
                    mode_next  = idle_mode;
                    sline_next = line_step;
                    scol_next  = col_step;
                    if (idle_num) begin
                        seen_next = 1'b0;
                    end
                end

                // end of input closes whatever is open, then back to reset values
                if (in_eoi) begin
                    c_r.kind = mode_kind(mode_next);
                    c_r.line = sat_line(sline_next);
                    c_r.col  = sat_col(scol_next);
                    if ((mode_next == MODE_IDENT) || (mode_next == MODE_ESCID) ||
                        (mode_next == MODE_NUMBER)) begin
                        c_v    = 1'b1;
                        c_r.ev = EV_END;
                    end else if ((mode_next == MODE_STRING) ||
                                 (mode_next == MODE_STRESC)) begin
                        c_v     = 1'b1;
                        c_r.ev  = EV_ERROR;
                        c_r.err = ERR_UNTERMINATED;
                    end
                    mode_next  = MODE_IDLE;
                    seen_next  = 1'b0;
                    line_next  = LINE_BITS'(1);
                    col_next   = '0;
                    sline_next = LINE_BITS'(1);
                    scol_next  = '0;
                end
            end
        end
    end

    // pack into at most two results; a one-character token at the final byte folds into its end
    always_comb begin
        n_res = 2'(a_v) + 2'(b_v) + 2'(c_v);
        if (a_v && b_v && c_v) begin
            o0       = a_r;
            o1       = c_r;
            o1.value = b_r.value;
            n_res    = 2'd2;
        end else begin
            o0 = a_v ? a_r : (b_v ? b_r : c_r);
            o1 = (a_v && b_v) ? b_r : c_r;
        end
        o0.last         = (n_res == 2'd1);
        o1.last         = 1'b1;
        push            = (n_res != 2'd0);
        push_grp.two    = (n_res == 2'd2);
        push_grp.first  = o0;
        push_grp.second = o1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            seen_reg  <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            sline_reg <= LINE_BITS'(1);
            scol_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            seen_reg  <= seen_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

endmodule

// ===== rtl/core/slx_queue.sv =====
// short queue of result groups between front and back end
module slx_queue
    import slx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  grp_t push_grp,
    output logic full,
    input  logic pop,
    output logic empty,
    output grp_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    grp_t          store [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == NW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_reg] <= push_grp;
        end
    end

endmodule

// ===== rtl/core/slx_back.sv =====
// back end: sends the one or two results of a queued group as separate transfers
module slx_back
    import slx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  grp_t               head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,
    output logic               m_tlast
);

    logic sel_reg, sel_next;
    logic xfer;
    res_t cur;

    assign cur      = sel_reg ? head.second : head.first;
    assign m_tvalid = !empty;
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && (sel_reg || !head.two);

    always_comb begin
        sel_next = sel_reg;
        if (xfer) begin
            sel_next = !pop;
        end
    end

    assign m_tdata = {(TDATA_W - TD_USED_W)'(0), cur.err, cur.col, cur.line, cur.value};
    assign m_tuser = {cur.kind, cur.ev};
    assign m_tlast = cur.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== rtl/core/source_lexer_stream.sv =====
// top level of the streaming source lexer
//
// slave side takes one source byte per transfer on s_tdata; s_tlast marks the
// last byte of a text, after which any open token is closed and the line and
// column counters start over for the next text
// master side gives one lexer result per transfer: value characters, token
// ends, brace tokens and errors, with m_tlast on the final result of a byte
// a byte gives zero, one or two results; after an error the lexer drops bytes
// without results until one arrives with s_tlast
// a result group is written into the queue before it shows on the master side
// throughput: one byte per cycle while each byte gives at most one result and
// the queue has room; a byte with two results takes two master transfers, so the
// output port with one transfer per cycle sets the sustained rate
// a queue of QUEUE_DEPTH result groups parts front and back end, so bytes
// keep flowing while a result waits; s_tready drops only when it is full
// reset (aresetn low, synchronous) empties the queue and sets line 1 col 0
// a stalled master side holds the current result steady until taken
module source_lexer_stream
    import slx_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,   // line counter width, 8 to 32
    parameter int COL_BITS    = COL_BITS_DEF,    // column counter width, 8 to 32
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // result groups in flight, 2 or more
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // source_byte
    input  logic               s_tlast,   // end_of_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // value_byte, token_line, token_col, error_code, zero pad
    output logic [TUSER_W-1:0] m_tuser,   // event_res, kind
    output logic               m_tlast    // last result of the byte
);

    logic s_xfer;
    logic push, full, pop, empty;
    grp_t push_grp, head;

    // a byte is taken whenever the queue has room for its results
    assign s_tready = !full;
    assign s_xfer   = s_tvalid && s_tready;

    slx_front #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_xfer),
        .in_byte   (s_tdata),
        .in_eoi    (s_tlast),
        .push      (push),
        .push_grp  (push_grp)
    );

    slx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    slx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/slx_check.sv =====
// port-level checks of the source lexer, bound to the top level
module slx_check
    import slx_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser,
    input logic               m_tlast
);

    event_t            ev;
    err_t              err;
    logic [BYTE_W-1:0] value;

    assign ev    = event_t'(m_tuser[1:0]);
    assign err   = err_t'(m_tdata[TD_ERR_LO +: 3]);
    assign value = m_tdata[TD_VALUE_LO +: BYTE_W];

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                   $stable(m_tlast))
        else $error("stalled result changed");

    // errors carry a code and no value, other events carry no code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((ev == EV_ERROR) ? (err != ERR_NONE && value == '0) : (err == ERR_NONE)))
        else $error("error code does not match event");

    // a brace token never has a result after it from the same byte
    a_brace_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ev == EV_BRACE |-> m_tlast)
        else $error("brace token not last of its byte");

    // an error ends the byte's results
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ev == EV_ERROR |-> m_tlast)
        else $error("error not last of its byte");

endmodule

bind source_lexer_stream slx_check u_slx_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
// self-checking testbench of the streaming source lexer, with its own token predictor
module tb_top;
    import slx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // identifier punctuation, next to the letters
    localparam logic [7:0] WORD_MARKS [7] = '{CH_POINT, CH_QUEST, CH_MINUS, CH_UNDER,
                                               CH_PLUS, CH_SLASH, CH_STAR};
    // letters that follow a backslash in a well-formed string escape
    localparam logic [7:0] ESC_LETTERS [9] = '{8'h6E, 8'h72, CH_QUOTE, 8'h61, 8'h65,
                                                8'h66, 8'h74, 8'h76, CH_BSLASH};

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata  = '0;    // source_byte
    logic               s_tlast  = 1'b0;  // end_of_input
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // value_byte, token_line, token_col, error_code
    logic [TUSER_W-1:0] m_tuser;          // event_res, kind
    logic               m_tlast;

    source_lexer_stream uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // one directed byte; a hand-written result replaces the predicted one when fixed is set
    typedef struct {
        logic [7:0] b;
        logic       eoi;
        bit         fixed;
        res_t       want;
    } stim_row_t;

    stim_row_t directed_q[$];
    res_t      token_q[$];      // results still owed by the lexer, oldest first
    int        errors        = 0;
    int        send_idle_pct = 0;
    int        rcv_stall_pct = 0;
    int        live_items    = 0;

    // predictor state
    mode_t            lx_mode;
    logic             lx_point;
    logic [POS_W-1:0] lx_line;
    logic [POS_W-1:0] lx_col;
    logic [POS_W-1:0] lx_st_line;
    logic [POS_W-1:0] lx_st_col;
    res_t             lex_pend [3];
    int               lex_npend;

    task automatic flag_error(input string what);
        errors++;
        $display("%0t ns: %s", $time, what);
    endtask

    function automatic string show_res(input res_t r);
        return $sformatf("ev %0d kind %0d value %02h at %0d:%0d err %0d last %0b",
                         r.ev, r.kind, r.value, r.line, r.col, r.err, r.last);
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == CH_POINT || c == CH_QUEST || c == CH_MINUS || c == CH_UNDER ||
               c == CH_PLUS || c == CH_SLASH || c == CH_STAR;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic kind_t tok_kind(input mode_t m);
        if (m == MODE_IDENT) return KIND_IDENT;
        if (m == MODE_ESCID) return KIND_ESCID;
        if (m == MODE_NUMBER) return KIND_NUMBER;
        return KIND_STRING;
    endfunction

    function automatic void lex_clear();
        lx_mode    = MODE_IDLE;
        lx_point   = 1'b0;
        lx_line    = POS_W'(1);
        lx_col     = '0;
        lx_st_line = POS_W'(1);
        lx_st_col  = '0;
    endfunction

    // at most three results per byte; the third only arises on a crowded final byte
    function automatic void note(input event_t ev, input kind_t k, input logic [7:0] v,
                                 input logic [POS_W-1:0] ln, input logic [POS_W-1:0] cl,
                                 input err_t e);
        if (lex_npend < 3) begin
            lex_pend[lex_npend] = '{ev: ev, kind: k, value: v, line: ln, col: cl,
                                    err: e, last: 1'b0};
            lex_npend++;
        end
    endfunction

    // results of one source byte into lex_pend, state moves on
    function automatic void lex_byte(input logic [7:0] b, input logic eoi);
        logic       again;
        logic [8:0] esc;
        lex_npend = 0;
        // halted after an error: bytes are dropped, the end of the text restarts
        if (lx_mode == MODE_HALT) begin
            if (eoi) lex_clear();
            return;
        end
        if (b == CH_NEWLINE) begin
            if (lx_line != POS_MAX) lx_line++;
            lx_col = 0;
        end else if (lx_col != POS_MAX) begin
            lx_col++;
        end
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (lx_mode)
                MODE_IDLE: begin
                    lx_st_line = lx_line;
                    lx_st_col  = lx_col;
                    if (b == CH_OPEN) begin
                        note(EV_BRACE, KIND_OPEN, 8'h00, lx_line, lx_col, ERR_NONE);
                    end else if (b == CH_CLOSE) begin
                        note(EV_BRACE, KIND_CLOSE, 8'h00, lx_line, lx_col, ERR_NONE);
                    end else if (word_byte(b)) begin
                        lx_mode = MODE_IDENT;
                        note(EV_CHAR, KIND_IDENT, b, lx_st_line, lx_st_col, ERR_NONE);
                    end else if (b == CH_QUOTE) begin
                        lx_mode = MODE_STRING;
                    end else if (b == CH_APOS) begin
                        lx_mode = MODE_ESCID;
                    end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
                        // white space only moves the position
                    end else if (digit_byte(b)) begin
                        lx_mode  = MODE_NUMBER;
                        lx_point = 1'b0;
                        note(EV_CHAR, KIND_NUMBER, b, lx_st_line, lx_st_col, ERR_NONE);
                    end else begin
                        note(EV_ERROR, KIND_NUMBER, 8'h00, lx_line, lx_col, ERR_UNEXPECTED);
                        lx_mode = MODE_HALT;
                    end
                end
                MODE_IDENT, MODE_ESCID: begin
                    if (word_byte(b)) begin
                        note(EV_CHAR, tok_kind(lx_mode), b, lx_st_line, lx_st_col, ERR_NONE);
                    end else begin
                        // the byte ends the token and is looked at again in idle
                        note(EV_END, tok_kind(lx_mode), 8'h00, lx_st_line, lx_st_col,
                             ERR_NONE);
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (b == CH_POINT && lx_point) begin
                        note(EV_ERROR, KIND_NUMBER, 8'h00, lx_line, lx_col, ERR_POINT);
                        lx_mode = MODE_HALT;
                    end else if (b == CH_POINT || digit_byte(b)) begin
                        if (b == CH_POINT) lx_point = 1'b1;
                        note(EV_CHAR, KIND_NUMBER, b, lx_st_line, lx_st_col, ERR_NONE);
                    end else begin
                        note(EV_END, KIND_NUMBER, 8'h00, lx_st_line, lx_st_col, ERR_NONE);
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (b == CH_BSLASH) begin
                        lx_mode = MODE_STRESC;
                    end else if (b == CH_QUOTE) begin
                        note(EV_END, KIND_STRING, 8'h00, lx_st_line, lx_st_col, ERR_NONE);
                        lx_mode = MODE_IDLE;
                    end else begin
                        note(EV_CHAR, KIND_STRING, b, lx_st_line, lx_st_col, ERR_NONE);
                    end
                end
                MODE_STRESC: begin
                    // n r " a e f t v and backslash are the known escapes
                    case (b)
                        8'h6E:     esc = {1'b1, 8'h0A};
                        8'h72:     esc = {1'b1, 8'h0D};
                        CH_QUOTE:  esc = {1'b1, CH_QUOTE};
                        8'h61:     esc = {1'b1, 8'h07};
                        8'h65:     esc = {1'b1, 8'h1B};
                        8'h66:     esc = {1'b1, 8'h0C};
                        8'h74:     esc = {1'b1, 8'h09};
                        8'h76:     esc = {1'b1, 8'h0B};
                        CH_BSLASH: esc = {1'b1, CH_BSLASH};
                        default:   esc = 9'h000;
                    endcase
                    if (esc[8]) begin
                        note(EV_CHAR, KIND_STRING, esc[7:0], lx_st_line, lx_st_col, ERR_NONE);
                        lx_mode = MODE_STRING;
                    end else begin
                        note(EV_ERROR, KIND_STRING, 8'h00, lx_line, lx_col, ERR_ESCAPE);
                        lx_mode = MODE_HALT;
                    end
                end
                default: ;
            endcase
        end
        // end of text closes the open token, then everything starts over
        if (eoi) begin
            if (lx_mode == MODE_IDENT || lx_mode == MODE_ESCID || lx_mode == MODE_NUMBER) begin
                note(EV_END, tok_kind(lx_mode), 8'h00, lx_st_line, lx_st_col, ERR_NONE);
            end else if (lx_mode == MODE_STRING || lx_mode == MODE_STRESC) begin
                note(EV_ERROR, KIND_STRING, 8'h00, lx_st_line, lx_st_col, ERR_UNTERMINATED);
            end
            lex_clear();
        end
        // crowded final byte: the new one-char token folds into its end event
        if (lex_npend == 3) begin
            lex_pend[2].value = lex_pend[1].value;
            lex_pend[1]       = lex_pend[2];
            lex_npend         = 2;
        end
        if (lex_npend > 0) lex_pend[lex_npend - 1].last = 1'b1;
    endfunction

    function automatic res_t fixed_res(input event_t ev, input kind_t k,
                                       input int ln, input int cl, input err_t e);
        return '{ev: ev, kind: k, value: 8'h00, line: POS_W'(ln), col: POS_W'(cl),
                 err: e, last: 1'b1};
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic eoi);
        directed_q.push_back('{b: b, eoi: eoi, fixed: 1'b0, want: '0});
    endfunction

    function automatic void add_fixed(input logic [7:0] b, input logic eoi, input res_t r);
        directed_q.push_back('{b: b, eoi: eoi, fixed: 1'b1, want: r});
    endfunction

    // one source byte: expectation first, then the transfer with optional gaps
    task automatic send_item(input logic [7:0] b, input logic eoi,
                             input bit fixed = 1'b0, input res_t want = '0);
        int k;
        if (lx_mode != MODE_HALT) live_items++;
        lex_byte(b, eoi);
        if (fixed) begin
            token_q.push_back(want);
        end else begin
            for (k = 0; k < lex_npend; k++) token_q.push_back(lex_pend[k]);
        end
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        // let the pipeline settle
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 58);
        if (r < 26) return 8'h41 + 8'(r);
        if (r < 52) return 8'h61 + 8'(r - 26);
        return WORD_MARKS[r - 52];
    endfunction

    // a random text of a few tokens, mostly well formed, ends on a byte with end of input
    task automatic send_text();
        logic [7:0] txt[$];
        int         ntok;
        int         t;
        int         k;
        int         n;
        int         pick;
        logic [7:0] c;
        ntok = $urandom_range(1, 8);
        for (t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                n = $urandom_range(1, 5);
                repeat (n) txt.push_back(word_char());
            end else if (pick < 36) begin
                n = $urandom_range(1, 4);
                repeat (n) txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0) begin
                    txt.push_back(CH_POINT);
                    n = $urandom_range(0, 3);
                    repeat (n) txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
                    // now and then a second point
                    if ($urandom_range(0, 19) == 0) txt.push_back(CH_POINT);
                end
            end else if (pick < 56) begin
                txt.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    k = $urandom_range(0, 39);
                    if (k == 0) begin
                        // mostly an unknown escape
                        txt.push_back(CH_BSLASH);
                        txt.push_back(8'($urandom_range(0, 255)));
                    end else if (k < 9) begin
                        txt.push_back(CH_BSLASH);
                        txt.push_back(ESC_LETTERS[$urandom_range(0, 8)]);
                    end else begin
                        c = 8'($urandom_range(32, 126));
                        if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h78;
                        txt.push_back(c);
                    end
                end
                txt.push_back(CH_QUOTE);
            end else if (pick < 66) begin
                txt.push_back(CH_APOS);
                n = $urandom_range(0, 4);
                repeat (n) txt.push_back(word_char());
            end else if (pick < 82) begin
                txt.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
            end else if (pick < 92) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
            // tokens also run together without a separator
            if ($urandom_range(0, 2) != 0) begin
                txt.push_back($urandom_range(0, 1) ? CH_SPACE : 8'(9 + $urandom_range(0, 4)));
            end
        end
        // cut some texts short so the end falls inside a token
        if (txt.size() > 1 && $urandom_range(0, 7) == 0) begin
            txt = txt[0:$urandom_range(0, txt.size() - 1)];
        end
        if (txt.size() == 0) txt.push_back(CH_SPACE);
        for (k = 0; k < txt.size(); k++) send_item(txt[k], k == txt.size() - 1);
    endtask

    // result side: compare every transfer with the oldest expectation, stall at random
    always @(posedge aclk) begin : take_results
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ev    = event_t'(m_tuser[1:0]);
            got.kind  = kind_t'(m_tuser[4:2]);
            got.value = m_tdata[TD_VALUE_LO +: BYTE_W];
            got.line  = m_tdata[TD_LINE_LO +: POS_W];
            got.col   = m_tdata[TD_COL_LO +: POS_W];
            got.err   = err_t'(m_tdata[TD_ERR_LO +: 3]);
            got.last  = m_tlast;
            if (token_q.size() == 0) begin
                flag_error({"result with nothing expected: ", show_res(got)});
            end else begin
                want = token_q.pop_front();
                // four-state compare so an unknown field fails too
                if (got !== want) begin
                    flag_error({"got ", show_res(got), " expected ", show_res(want)});
                end
            end
        end
        m_tready <= !(rcv_stall_pct > 0 && $urandom_range(99) < rcv_stall_pct);
    end

    initial begin : run_stimulus
        int  ph;
        int  goal;
        bit  paused;
        lex_clear();

        // directed texts; hand-written results for braces, errors and extremes
        add_fixed(CH_OPEN, 1'b0, fixed_res(EV_BRACE, KIND_OPEN, 1, 1, ERR_NONE));
        add_fixed(CH_CLOSE, 1'b0, fixed_res(EV_BRACE, KIND_CLOSE, 1, 2, ERR_NONE));
        add_row(8'h61, 1'b0);                   // identifier starts
        add_row(8'h39, 1'b0);                   // ends it and starts a number
        add_row(CH_POINT, 1'b0);
        add_fixed(CH_POINT, 1'b0, fixed_res(EV_ERROR, KIND_NUMBER, 1, 6, ERR_POINT));
        add_row(8'hFF, 1'b0);                   // dropped while halted
        add_row(8'h00, 1'b1);                   // halted end of text restarts
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSLASH, 1'b0);
        add_row(8'h6E, 1'b0);                   // decoded newline
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_APOS, 1'b0);
        add_row(CH_UNDER, 1'b0);
        add_row(CH_SPACE, 1'b0);
        add_row(CH_NEWLINE, 1'b0);
        add_fixed(8'h80, 1'b0, fixed_res(EV_ERROR, KIND_NUMBER, 2, 1, ERR_UNEXPECTED));
        add_row(8'h71, 1'b1);
        add_row(CH_QUOTE, 1'b0);
        add_row(8'h61, 1'b1);                   // char, then unterminated string
        add_row(CH_APOS, 1'b1);                 // empty escaped identifier
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSLASH, 1'b0);
        add_fixed(8'h71, 1'b1, fixed_res(EV_ERROR, KIND_STRING, 1, 3, ERR_ESCAPE));
        add_row(8'h61, 1'b0);
        add_row(8'h31, 1'b1);                   // crowded final byte
        add_row(CH_QUOTE, 1'b0);
        add_fixed(CH_BSLASH, 1'b1,
                  fixed_res(EV_ERROR, KIND_STRING, 1, 1, ERR_UNTERMINATED));
        add_fixed(8'h00, 1'b1, fixed_res(EV_ERROR, KIND_NUMBER, 1, 1, ERR_UNEXPECTED));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_q[r]) begin
            send_item(directed_q[r].b, directed_q[r].eoi, directed_q[r].fixed,
                      directed_q[r].want);
        end

        // random texts under four idling patterns
        paused = 1'b0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; rcv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rcv_stall_pct = 47; end
                default: begin send_idle_pct = 10; rcv_stall_pct = 10; end
            endcase
            goal = live_items + 125;
            while (live_items < goal) begin
                send_text();
                // sender holds off once until the result side has caught up
                if (ph == 1 && !paused && live_items >= goal - 60) begin
                    wait_drain();
                    paused = 1'b1;
                end
            end
        end

        wait_drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #16_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
